/* rtl/recursive_lock_fifo_waiters_defines.svh */
// assertion macros for the lock unit checker
// no dependencies
`ifndef RECURSIVE_LOCK_FIFO_WAITERS_DEFINES_SVH
`define RECURSIVE_LOCK_FIFO_WAITERS_DEFINES_SVH

// same-cycle implication
`define RLFW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lock unit check failed");

// next-cycle implication
`define RLFW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lock unit check failed");

`endif

/* rtl/rlfw_pkg.sv */
// shared types and constants of the recursive lock unit
// no dependencies
package rlfw_pkg;

   localparam int ACTION_W = 2;
   localparam int TASK_W   = 8;
   localparam int FLAGS_W  = 8;
   localparam int STATUS_W = 4;
   localparam int NEST_W   = 8;

   localparam logic [ACTION_W-1:0] ACT_LOCK   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_UNLOCK = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_GRANTED    = 4'd0;
   localparam logic [STATUS_W-1:0] ST_NESTED     = 4'd1;
   localparam logic [STATUS_W-1:0] ST_BUSY       = 4'd2;
   localparam logic [STATUS_W-1:0] ST_QUEUED     = 4'd3;
   localparam logic [STATUS_W-1:0] ST_RELEASED   = 4'd4;
   localparam logic [STATUS_W-1:0] ST_HANDED     = 4'd5;
   localparam logic [STATUS_W-1:0] ST_UNNESTED   = 4'd6;
   localparam logic [STATUS_W-1:0] ST_NOT_OWNER  = 4'd7;
   localparam logic [STATUS_W-1:0] ST_BAD_FLAGS  = 4'd8;
   localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 4'd9;
   localparam logic [STATUS_W-1:0] ST_ABORTED    = 4'd10;
   localparam logic [STATUS_W-1:0] ST_DELETED    = 4'd11;

   localparam logic [NEST_W-1:0] NEST_MAX = 8'hff;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DRAIN
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic pop;
      logic del_done;
   } cmd_type;

   typedef struct packed {
      logic is_delete;
      logic is_noop;
      logic fifo_empty;
      logic out_free;
   } stat_type;

endpackage

/* rtl/recursive_lock_fifo_waiters.sv */
// recursive lock unit: one mutex with a fifo of waiting tasks
// flow: a beat is accepted in S_IDLE and its result is registered in S_EXEC once the output is free
// lock and unlock are handled one at a time; delete aborts each waiter in turn, then reports deleted,
// one aborted beat per cycle from the queue ram read port while the output is not stalled
// reset: synchronous, active high; unlocked, empty queue, no result pending
// depends on rlfw_pkg, rlfw_ctrl, rlfw_dp and rlfw_ram
module recursive_lock_fifo_waiters #(
   parameter int QUEUE_DEPTH  = 8,
   parameter int TASK_ID_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // action[1:0], task_id[9:2], lock_flags[17:10], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[3:0], target_task[11:4], zero pad
   output logic        rsp_tlast
);

   rlfw_pkg::cmd_type  cmd;
   rlfw_pkg::stat_type stat;

   rlfw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rlfw_dp #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

/* rtl/rlfw_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module rlfw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/rlfw_ctrl.sv */
// controller state machine of the lock unit
// depends on rlfw_pkg
module rlfw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  rlfw_pkg::stat_type stat,
   output rlfw_pkg::cmd_type  cmd
);

   rlfw_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rlfw_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rlfw_pkg::S_IDLE: begin
            if (req_tvalid) state_in = rlfw_pkg::S_EXEC;
         end
         rlfw_pkg::S_EXEC: begin
            if (stat.is_noop) begin
               state_in = rlfw_pkg::S_IDLE;
            end else if (stat.is_delete) begin
               state_in = rlfw_pkg::S_DRAIN;
            end else if (stat.out_free) begin
               state_in = rlfw_pkg::S_IDLE;
            end
         end
         rlfw_pkg::S_DRAIN: begin
            if (stat.out_free && stat.fifo_empty) state_in = rlfw_pkg::S_IDLE;
         end
         default: state_in = rlfw_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         rlfw_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         rlfw_pkg::S_EXEC: begin
            cmd.exec = !stat.is_noop && !stat.is_delete && stat.out_free;
         end
         rlfw_pkg::S_DRAIN: begin
            cmd.pop      = stat.out_free && !stat.fifo_empty;
            cmd.del_done = stat.out_free && stat.fifo_empty;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* rtl/rlfw_dp.sv */
// datapath of the lock unit: request register, lock state, waiter queue, result register
// depends on rlfw_pkg and rlfw_ram
module rlfw_dp #(
   parameter int QUEUE_DEPTH  = 8,
   parameter int TASK_ID_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [23:0]                   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,
   output logic                          rsp_tlast,
   input  rlfw_pkg::cmd_type              cmd,
   output rlfw_pkg::stat_type             stat
);

   localparam int TW = (TASK_ID_BITS < rlfw_pkg::TASK_W) ? TASK_ID_BITS : rlfw_pkg::TASK_W;
   localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;

   logic [rlfw_pkg::ACTION_W-1:0] action_ff;
   logic [TW-1:0]                 task_ff;
   logic [rlfw_pkg::FLAGS_W-1:0]  flags_ff;

   logic                          locked_ff, locked_in;
   logic [TW-1:0]                 owner_ff, owner_in;
   logic [rlfw_pkg::NEST_W-1:0]   nest_ff, nest_in;
   logic [HW-1:0]                 head_ff, head_in;
   logic [CW-1:0]                 count_ff, count_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rlfw_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [rlfw_pkg::TASK_W-1:0]   rsp_task_ff, rsp_task_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic [TW-1:0]                 head_task;
   logic                          wr_en;
   logic [HW-1:0]                 tail;
   logic [SW-1:0]                 tail_sum;
   logic [HW-1:0]                 head_next;
   logic                          out_free;
   logic                          emit;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_tdata[1:0];
         task_ff   <= req_tdata[2 +: TW];
         flags_ff  <= req_tdata[17:10];
      end
   end

   assign tail_sum  = SW'(head_ff) + SW'(count_ff);
   assign tail      = (tail_sum >= SW'(QUEUE_DEPTH)) ? HW'(tail_sum - SW'(QUEUE_DEPTH))
                                                      : HW'(tail_sum);
   assign head_next = (head_ff == HW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + HW'(1);

   rlfw_ram #(
      .WIDTH (TW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail),
      .wr_data (task_ff),
      .rd_addr (head_in),
      .rd_data (head_task)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      locked_in     = locked_ff;
      owner_in      = owner_ff;
      nest_in       = nest_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      wr_en         = 1'b0;
      emit          = 1'b0;
      rsp_status_in = rlfw_pkg::ST_GRANTED;
      rsp_task_in   = rlfw_pkg::TASK_W'(task_ff);
      rsp_last_in   = 1'b1;
      if (cmd.exec) begin
         emit = 1'b1;
         if (action_ff == rlfw_pkg::ACT_LOCK) begin
            priority if (|flags_ff[rlfw_pkg::FLAGS_W-1:1]) begin
               rsp_status_in = rlfw_pkg::ST_BAD_FLAGS;
            end else if (!locked_ff) begin
               locked_in     = 1'b1;
               owner_in      = task_ff;
               nest_in       = rlfw_pkg::NEST_W'(1);
               rsp_status_in = rlfw_pkg::ST_GRANTED;
            end else if (owner_ff == task_ff) begin
               if (nest_ff == rlfw_pkg::NEST_MAX) begin
                  rsp_status_in = rlfw_pkg::ST_QUEUE_FULL;
               end else begin
                  nest_in       = nest_ff + rlfw_pkg::NEST_W'(1);
                  rsp_status_in = rlfw_pkg::ST_NESTED;
               end
            end else if (!flags_ff[0]) begin
               rsp_status_in = rlfw_pkg::ST_BUSY;
            end else if (count_ff == CW'(QUEUE_DEPTH)) begin
               rsp_status_in = rlfw_pkg::ST_QUEUE_FULL;
            end else begin
               wr_en         = 1'b1;
               count_in      = count_ff + CW'(1);
               rsp_status_in = rlfw_pkg::ST_QUEUED;
            end
         end else begin
            priority if (!locked_ff || owner_ff != task_ff) begin
               rsp_status_in = rlfw_pkg::ST_NOT_OWNER;
            end else if (nest_ff > rlfw_pkg::NEST_W'(1)) begin
               nest_in       = nest_ff - rlfw_pkg::NEST_W'(1);
               rsp_status_in = rlfw_pkg::ST_UNNESTED;
            end else if (count_ff != '0) begin
               owner_in      = head_task;
               nest_in       = rlfw_pkg::NEST_W'(1);
               head_in       = head_next;
               count_in      = count_ff - CW'(1);
               rsp_status_in = rlfw_pkg::ST_HANDED;
               rsp_task_in   = rlfw_pkg::TASK_W'(head_task);
            end else begin
               locked_in     = 1'b0;
               owner_in      = '0;
               nest_in       = '0;
               rsp_status_in = rlfw_pkg::ST_RELEASED;
            end
         end
      end else if (cmd.pop) begin
         emit          = 1'b1;
         head_in       = head_next;
         count_in      = count_ff - CW'(1);
         rsp_status_in = rlfw_pkg::ST_ABORTED;
         rsp_task_in   = rlfw_pkg::TASK_W'(head_task);
         rsp_last_in   = 1'b0;
      end else if (cmd.del_done) begin
         emit          = 1'b1;
         locked_in     = 1'b0;
         owner_in      = '0;
         nest_in       = '0;
         head_in       = '0;
         count_in      = '0;
         rsp_status_in = rlfw_pkg::ST_DELETED;
      end
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff    <= 1'b0;
         owner_ff     <= '0;
         nest_ff      <= '0;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         locked_ff    <= locked_in;
         owner_ff     <= owner_in;
         nest_ff      <= nest_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_task_ff   <= rsp_task_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign stat.is_delete  = (action_ff == rlfw_pkg::ACT_DELETE);
   assign stat.is_noop    = (action_ff != rlfw_pkg::ACT_LOCK) &&
                            (action_ff != rlfw_pkg::ACT_UNLOCK) &&
                            (action_ff != rlfw_pkg::ACT_DELETE);
   assign stat.fifo_empty = (count_ff == '0);
   assign stat.out_free   = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_task_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/rlfw_checker.sv */
// port-level checks of the lock unit, bound to the top level
// depends on rlfw_pkg and recursive_lock_fifo_waiters_defines.svh
`include "recursive_lock_fifo_waiters_defines.svh"

module rlfw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic rsp_stall;
   logic is_aborted;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign is_aborted = (rsp_tdata[3:0] == rlfw_pkg::ST_ABORTED);

   // a stalled result beat holds
   `RLFW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // only aborted beats are not the last of their request
   `RLFW_ASSERT_NOW(a_last_marks, clock, reset, rsp_tvalid, is_aborted == !rsp_tlast)

   // status codes stay in the defined range
   `RLFW_ASSERT_NOW(a_status_range, clock, reset, rsp_tvalid, rsp_tdata[3:0] <= rlfw_pkg::ST_DELETED)

   // one request at a time: no accept right after an accept
   `RLFW_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)

   // padding bits of the result beat are zero
   `RLFW_ASSERT_NOW(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[15:12] == 4'b0000)

endmodule

bind recursive_lock_fifo_waiters rlfw_checker u_rlfw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
